>>> design/pla_pkg.sv
// Shared types, field layout and request kind codes for the piecewise linear activation block.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package pla_pkg;

   // default sizing
   localparam int NEURONS_DEF  = 256;
   localparam int SEGMENTS_DEF = 8;

   // field widths
   localparam int KIND_W    = 3;
   localparam int NEURON_W  = 8;
   localparam int SEG_W     = 3;
   localparam int VAL_W     = 16;
   localparam int RES_W     = 48;
   localparam int PROD_W    = 33;
   localparam int REQ_DATA_W = 48;

   // request tdata layout, lowest field first
   localparam int NEURON_LSB = 0;
   localparam int SEG_LSB    = NEURON_LSB + NEURON_W;
   localparam int VAL_LSB    = SEG_LSB + SEG_W;
   localparam int GRAD_LSB   = VAL_LSB + VAL_W;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_WR_SLOPE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WR_OFFSET = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BACKWARD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RD_SGRAD = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RD_OGRAD = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd6;

   // parameter table controls
   typedef struct packed {
      logic wr_slope;
      logic wr_offset;
      logic rd;
   } pm_ctl_type;

   // gradient store controls
   typedef struct packed {
      logic rd;
      logic upd;
      logic clr;
   } gm_ctl_type;

   // one finished result
   typedef struct packed {
      logic [RES_W-1:0] result;
      logic             saturated;
   } rsp_item_type;

   // engine status
   typedef struct packed {
      logic clearing;
      logic busy;
   } eng_stat_type;

endpackage

`default_nettype wire

>>> design/piecewise_linear_activation_top.sv
// Piecewise linear activation engine: per-neuron hinge tables, forward and backward passes.
// Forward/backward: one segment per cycle through the table read port; a new request is
// taken once the result is handed off. Reset is synchronous; afterwards a sweep zeroes the
// gradient stores while req_tready stays low.
`default_nettype none

module piecewise_linear_activation_top #(
   parameter int NEURONS  = pla_pkg::NEURONS_DEF,
   parameter int SEGMENTS = pla_pkg::SEGMENTS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // neuron[7:0], segment[10:8], value[26:11], upstream_grad[42:27], zero fill[47:43]
   input  wire  [pla_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[2:0]
   input  wire  [pla_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // result[47:0]
   output logic [pla_pkg::RES_W-1:0]        rsp_tdata,
   // saturated[0]
   output logic [0:0]                       rsp_tuser
);

   localparam int DEPTH  = NEURONS * SEGMENTS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pla_pkg::pm_ctl_type                pm_ctl;
   logic        [ADDR_W-1:0]           pm_wr_addr;
   logic signed [pla_pkg::VAL_W-1:0]   pm_wr_data;
   logic        [ADDR_W-1:0]           pm_rd_addr;
   logic signed [pla_pkg::VAL_W-1:0]   pm_slope;
   logic signed [pla_pkg::VAL_W-1:0]   pm_offset;
   pla_pkg::gm_ctl_type                gm_ctl;
   logic        [ADDR_W-1:0]           gm_rd_addr;
   logic        [ADDR_W-1:0]           gm_wr_addr;
   logic signed [pla_pkg::PROD_W-1:0]  gm_inc_slope;
   logic signed [pla_pkg::PROD_W-1:0]  gm_inc_offset;
   logic signed [pla_pkg::RES_W-1:0]   gm_slope;
   logic signed [pla_pkg::RES_W-1:0]   gm_offset;
   logic                               eng_vld;
   logic                               eng_ack;
   pla_pkg::rsp_item_type              eng_item;
   pla_pkg::eng_stat_type              eng_stat;

   logic                               rsp_vld_ff;
   logic [pla_pkg::RES_W-1:0]          rsp_data_ff;
   logic                               rsp_sat_ff;

   pla_engine #(
      .NEURONS  (NEURONS),
      .SEGMENTS (SEGMENTS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .pm_ctl        (pm_ctl),
      .pm_wr_addr    (pm_wr_addr),
      .pm_wr_data    (pm_wr_data),
      .pm_rd_addr    (pm_rd_addr),
      .pm_slope      (pm_slope),
      .pm_offset     (pm_offset),
      .gm_ctl        (gm_ctl),
      .gm_rd_addr    (gm_rd_addr),
      .gm_wr_addr    (gm_wr_addr),
      .gm_inc_slope  (gm_inc_slope),
      .gm_inc_offset (gm_inc_offset),
      .gm_slope      (gm_slope),
      .gm_offset     (gm_offset),
      .eng_vld       (eng_vld),
      .eng_ack       (eng_ack),
      .eng_item      (eng_item),
      .eng_stat      (eng_stat)
   );

   pla_param_mem #(
      .NEURONS  (NEURONS),
      .SEGMENTS (SEGMENTS)
   ) u_param_mem (
      .clock     (clock),
      .ctl       (pm_ctl),
      .wr_addr   (pm_wr_addr),
      .wr_data   (pm_wr_data),
      .rd_addr   (pm_rd_addr),
      .rd_slope  (pm_slope),
      .rd_offset (pm_offset)
   );

   pla_grad_mem #(
      .NEURONS  (NEURONS),
      .SEGMENTS (SEGMENTS)
   ) u_grad_mem (
      .clock      (clock),
      .ctl        (gm_ctl),
      .rd_addr    (gm_rd_addr),
      .wr_addr    (gm_wr_addr),
      .inc_slope  (gm_inc_slope),
      .inc_offset (gm_inc_offset),
      .rd_slope   (gm_slope),
      .rd_offset  (gm_offset)
   );

   // hand a result to the output register whenever it is empty or draining
   assign eng_ack = eng_vld && (!rsp_vld_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (eng_ack) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_ack) begin
         rsp_data_ff <= eng_item.result;
         rsp_sat_ff  <= eng_item.saturated;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

`ifndef SYNTH
   // a posted result holds until the output register takes it
   a_post_hold: assert property (@(posedge clock) disable iff (reset)
      (eng_vld && !eng_ack) |=> (eng_vld && $stable(eng_item)))
      else $error("engine result changed before hand-off");

   // the output register fills only from an engine hand-off
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(eng_ack))
      else $error("response valid without engine hand-off");

   // an in-range forward or backward request keeps the engine busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready
       && (req_tuser == pla_pkg::KIND_FORWARD || req_tuser == pla_pkg::KIND_BACKWARD)
       && (13'(req_tdata[pla_pkg::NEURON_W-1:0]) < 13'(NEURONS)))
      |=> (eng_stat.busy && !req_tready))
      else $error("engine idle right after a pass request");

   // leaving reset starts the gradient sweep
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> eng_stat.clearing)
      else $error("gradient sweep not running after reset");
`endif

endmodule

`default_nettype wire

>>> design/pla_param_mem.sv
// Slope and offset tables: two synchronous memories, one write and one read port each.
// Depends on pla_pkg for the control struct and value width.
`default_nettype none

module pla_param_mem #(
   parameter int  NEURONS  = pla_pkg::NEURONS_DEF,
   parameter int  SEGMENTS = pla_pkg::SEGMENTS_DEF,
   localparam int DEPTH    = NEURONS * SEGMENTS,
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                                clock,
   input  pla_pkg::pm_ctl_type                ctl,
   input  wire        [ADDR_W-1:0]            wr_addr,
   input  wire signed [pla_pkg::VAL_W-1:0]    wr_data,
   input  wire        [ADDR_W-1:0]            rd_addr,
   output logic signed [pla_pkg::VAL_W-1:0]   rd_slope,
   output logic signed [pla_pkg::VAL_W-1:0]   rd_offset
);

   logic [pla_pkg::VAL_W-1:0] slope_mem  [DEPTH];
   logic [pla_pkg::VAL_W-1:0] offset_mem [DEPTH];
   logic [pla_pkg::VAL_W-1:0] slope_q_ff;
   logic [pla_pkg::VAL_W-1:0] offset_q_ff;

   // write either table, read both into registered outputs
   always_ff @(posedge clock) begin
      if (ctl.wr_slope) begin
         slope_mem[wr_addr] <= wr_data;
      end
      if (ctl.wr_offset) begin
         offset_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd) begin
         slope_q_ff  <= slope_mem[rd_addr];
         offset_q_ff <= offset_mem[rd_addr];
      end
   end

   assign rd_slope  = slope_q_ff;
   assign rd_offset = offset_q_ff;

endmodule

`default_nettype wire

>>> design/pla_grad_mem.sv
// Slope and offset gradient stores: two 48-bit memories with saturating read-modify-write.
// Depends on pla_pkg for the control struct and widths.
`default_nettype none

module pla_grad_mem #(
   parameter int  NEURONS  = pla_pkg::NEURONS_DEF,
   parameter int  SEGMENTS = pla_pkg::SEGMENTS_DEF,
   localparam int DEPTH    = NEURONS * SEGMENTS,
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                                 clock,
   input  pla_pkg::gm_ctl_type                 ctl,
   input  wire        [ADDR_W-1:0]             rd_addr,
   input  wire        [ADDR_W-1:0]             wr_addr,
   input  wire signed [pla_pkg::PROD_W-1:0]    inc_slope,
   input  wire signed [pla_pkg::PROD_W-1:0]    inc_offset,
   output logic signed [pla_pkg::RES_W-1:0]    rd_slope,
   output logic signed [pla_pkg::RES_W-1:0]    rd_offset
);

   localparam int EXT_W = pla_pkg::RES_W + 1 - pla_pkg::PROD_W;
   localparam logic [pla_pkg::RES_W-1:0] ACC_MAX = {1'b0, {(pla_pkg::RES_W-1){1'b1}}};
   localparam logic [pla_pkg::RES_W-1:0] ACC_MIN = {1'b1, {(pla_pkg::RES_W-1){1'b0}}};

   logic [pla_pkg::RES_W-1:0] slope_mem  [DEPTH];
   logic [pla_pkg::RES_W-1:0] offset_mem [DEPTH];
   logic [pla_pkg::RES_W-1:0] slope_q_ff;
   logic [pla_pkg::RES_W-1:0] offset_q_ff;
   logic [pla_pkg::RES_W-1:0] slope_wd;
   logic [pla_pkg::RES_W-1:0] offset_wd;
   logic                      wr_en;

   // add with clipping to the 48-bit signed range
   function automatic logic [pla_pkg::RES_W-1:0] sat_add(
      input logic [pla_pkg::RES_W-1:0]  acc,
      input logic [pla_pkg::PROD_W-1:0] inc
   );
      logic [pla_pkg::RES_W:0] sum;
      sum = {acc[pla_pkg::RES_W-1], acc} + {{EXT_W{inc[pla_pkg::PROD_W-1]}}, inc};
      if (sum[pla_pkg::RES_W] != sum[pla_pkg::RES_W-1]) begin
         return sum[pla_pkg::RES_W] ? ACC_MIN : ACC_MAX;
      end
      return sum[pla_pkg::RES_W-1:0];
   endfunction

   // clear writes zero, update folds the increment into the entry just read
   always_comb begin
      wr_en     = ctl.clr || ctl.upd;
      slope_wd  = ctl.clr ? '0 : sat_add(slope_q_ff, inc_slope);
      offset_wd = ctl.clr ? '0 : sat_add(offset_q_ff, inc_offset);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slope_mem[wr_addr]  <= slope_wd;
         offset_mem[wr_addr] <= offset_wd;
      end
      if (ctl.rd) begin
         slope_q_ff  <= slope_mem[rd_addr];
         offset_q_ff <= offset_mem[rd_addr];
      end
   end

   assign rd_slope  = slope_q_ff;
   assign rd_offset = offset_q_ff;

endmodule

`default_nettype wire

>>> design/pla_engine.sv
// Request decoder, segment sequencer and multiply-accumulate pipeline.
// Depends on pla_pkg; drives pla_param_mem and pla_grad_mem.
`default_nettype none

module pla_engine #(
   parameter int  NEURONS  = pla_pkg::NEURONS_DEF,
   parameter int  SEGMENTS = pla_pkg::SEGMENTS_DEF,
   localparam int DEPTH    = NEURONS * SEGMENTS,
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [pla_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire  [pla_pkg::KIND_W-1:0]            req_tuser,
   output pla_pkg::pm_ctl_type                   pm_ctl,
   output logic        [ADDR_W-1:0]              pm_wr_addr,
   output logic signed [pla_pkg::VAL_W-1:0]      pm_wr_data,
   output logic        [ADDR_W-1:0]              pm_rd_addr,
   input  wire  signed [pla_pkg::VAL_W-1:0]      pm_slope,
   input  wire  signed [pla_pkg::VAL_W-1:0]      pm_offset,
   output pla_pkg::gm_ctl_type                   gm_ctl,
   output logic        [ADDR_W-1:0]              gm_rd_addr,
   output logic        [ADDR_W-1:0]              gm_wr_addr,
   output logic signed [pla_pkg::PROD_W-1:0]     gm_inc_slope,
   output logic signed [pla_pkg::PROD_W-1:0]     gm_inc_offset,
   input  wire  signed [pla_pkg::RES_W-1:0]      gm_slope,
   input  wire  signed [pla_pkg::RES_W-1:0]      gm_offset,
   output logic                                  eng_vld,
   input  wire                                   eng_ack,
   output pla_pkg::rsp_item_type                 eng_item,
   output pla_pkg::eng_stat_type                 eng_stat
);

   localparam int CNT_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int ACC_W  = pla_pkg::PROD_W + 2 + $clog2(SEGMENTS + 1);
   localparam int MUL_W  = pla_pkg::NEURON_W + 6;
   localparam int LIM_W  = 13;
   localparam int SLIM_W = 6;
   localparam int H_W    = pla_pkg::VAL_W + 1;

   localparam logic [LIM_W-1:0]  NEURON_LIM = LIM_W'(NEURONS);
   localparam logic [SLIM_W-1:0] SEG_LIM    = SLIM_W'(SEGMENTS);
   localparam logic [CNT_W-1:0]  ISS_LAST   = CNT_W'(SEGMENTS - 1);
   localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(DEPTH - 1);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(128);
   localparam logic signed [ACC_W-1:0] Q_MAX    = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Q_MIN    = -ACC_W'(32768);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_POST  = 3'd5;

   // request fields
   logic        [pla_pkg::KIND_W-1:0]   req_kind;
   logic        [pla_pkg::NEURON_W-1:0] req_neuron;
   logic        [pla_pkg::SEG_W-1:0]    req_seg;
   logic signed [pla_pkg::VAL_W-1:0]    req_value;
   logic signed [pla_pkg::VAL_W-1:0]    req_grad;
   logic        [MUL_W-1:0]             req_base_w;
   logic        [ADDR_W-1:0]            req_base;
   logic        [ADDR_W-1:0]            req_addr;
   logic                                neuron_ok;
   logic                                seg_ok;
   logic                                take;
   logic                                start_run;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              iss_on_ff, iss_on_in;
   logic              iss_act;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   pla_pkg::rsp_item_type   res_ff, res_in;

   // per-item payload
   logic [ADDR_W-1:0]                 base_ff;
   logic [pla_pkg::KIND_W-1:0]        kind_ff;
   logic signed [pla_pkg::VAL_W-1:0]  x_ff;
   logic signed [pla_pkg::VAL_W-1:0]  g_ff;
   logic                              bwd;

   // pipeline stages
   logic                          p1_vld_ff, p1_last_ff;
   logic [ADDR_W-1:0]             p1_addr_ff;
   logic                          p2_vld_ff, p2_last_ff;
   logic [ADDR_W-1:0]             p2_addr_ff;
   logic signed [H_W-1:0]         p2_h_ff;
   logic signed [pla_pkg::VAL_W-1:0] p2_slope_ff;
   logic signed [H_W-1:0]         mul_op;
   logic                          p3_vld_ff, p3_last_ff, p3_hpos_ff;
   logic [ADDR_W-1:0]             p3_addr_ff;
   logic signed [pla_pkg::PROD_W-1:0] p3_term_ff;
   logic signed [pla_pkg::PROD_W-1:0] p3_gh_ff;

   // rounding
   logic signed [ACC_W-1:0]          rnd_t;
   logic signed [ACC_W-1:0]          rnd_r;
   logic        [pla_pkg::VAL_W-1:0] rnd_q;
   logic                             rnd_sat;

   // unpack and range check the request
   always_comb begin
      req_kind   = req_tuser;
      req_neuron = req_tdata[pla_pkg::NEURON_LSB +: pla_pkg::NEURON_W];
      req_seg    = req_tdata[pla_pkg::SEG_LSB +: pla_pkg::SEG_W];
      req_value  = req_tdata[pla_pkg::VAL_LSB +: pla_pkg::VAL_W];
      req_grad   = req_tdata[pla_pkg::GRAD_LSB +: pla_pkg::VAL_W];
      req_base_w = MUL_W'(req_neuron) * MUL_W'(SEGMENTS);
      req_base   = ADDR_W'(req_base_w);
      req_addr   = req_base + ADDR_W'(req_seg);
      neuron_ok  = LIM_W'(req_neuron) < NEURON_LIM;
      seg_ok     = SLIM_W'(req_seg) < SEG_LIM;
      req_tready = (state_ff == ST_IDLE);
      take       = req_tvalid && req_tready;
      bwd        = (kind_ff == pla_pkg::KIND_BACKWARD);
   end

   // round Q16.16 to nearest Q8.8, ties up, then clip
   always_comb begin
      rnd_t   = acc_ff + RND_HALF;
      rnd_r   = rnd_t >>> 8;
      rnd_sat = 1'b0;
      rnd_q   = rnd_r[pla_pkg::VAL_W-1:0];
      if (rnd_r > Q_MAX) begin
         rnd_q   = 16'h7fff;
         rnd_sat = 1'b1;
      end else if (rnd_r < Q_MIN) begin
         rnd_q   = 16'h8000;
         rnd_sat = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      iss_in     = iss_ff;
      iss_on_in  = iss_on_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      start_run  = 1'b0;
      pm_ctl     = '0;
      gm_ctl     = '0;
      eng_vld    = 1'b0;
      iss_act    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            gm_ctl.clr = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               unique case (req_kind) inside
                  pla_pkg::KIND_WR_SLOPE: begin
                     pm_ctl.wr_slope = neuron_ok && seg_ok;
                  end
                  pla_pkg::KIND_WR_OFFSET: begin
                     pm_ctl.wr_offset = neuron_ok && seg_ok;
                  end
                  pla_pkg::KIND_FORWARD, pla_pkg::KIND_BACKWARD: begin
                     if (neuron_ok) begin
                        start_run = 1'b1;
                        state_in  = ST_RUN;
                        iss_in    = '0;
                        iss_on_in = 1'b1;
                        acc_in    = '0;
                        if (!req_value[pla_pkg::VAL_W-1] && (req_value != '0)) begin
                           if (req_kind == pla_pkg::KIND_FORWARD) begin
                              acc_in = ACC_W'(req_value) <<< 8;
                           end else begin
                              acc_in = ACC_W'(req_grad) <<< 8;
                           end
                        end
                     end
                  end
                  pla_pkg::KIND_RD_SGRAD, pla_pkg::KIND_RD_OGRAD: begin
                     if (neuron_ok && seg_ok) begin
                        gm_ctl.rd = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  pla_pkg::KIND_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            // issue one segment a cycle
            if (iss_on_ff) begin
               iss_act   = 1'b1;
               pm_ctl.rd = 1'b1;
               if (iss_ff == ISS_LAST) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_in = iss_ff + 1'b1;
               end
            end
            // fetch the gradient entries one stage ahead of their update
            gm_ctl.rd = p2_vld_ff && bwd;
            // accumulate active hinges; on backward passes also update the gradient stores
            if (p3_vld_ff && p3_hpos_ff) begin
               if (bwd) begin
                  acc_in     = acc_ff - ACC_W'(p3_term_ff);
                  gm_ctl.upd = 1'b1;
               end else begin
                  acc_in = acc_ff + ACC_W'(p3_term_ff);
               end
            end
            if (p3_vld_ff && p3_last_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_READ: begin
            res_in.result    = (kind_ff == pla_pkg::KIND_RD_SGRAD) ? gm_slope : gm_offset;
            res_in.saturated = 1'b0;
            state_in         = ST_POST;
         end
         ST_FIN: begin
            res_in.result    = {{(pla_pkg::RES_W - pla_pkg::VAL_W){rnd_q[pla_pkg::VAL_W-1]}},
                                rnd_q};
            res_in.saturated = rnd_sat;
            state_in         = ST_POST;
         end
         ST_POST: begin
            eng_vld = 1'b1;
            if (eng_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory addressing
   always_comb begin
      pm_wr_addr    = req_addr;
      pm_wr_data    = req_value;
      pm_rd_addr    = base_ff + ADDR_W'(iss_ff);
      gm_rd_addr    = (state_ff == ST_IDLE) ? req_addr : p2_addr_ff;
      gm_wr_addr    = (state_ff == ST_CLEAR) ? clr_cnt_ff : p3_addr_ff;
      gm_inc_slope  = p3_gh_ff;
      gm_inc_offset = p3_term_ff;
      mul_op        = bwd ? H_W'(g_ff) : p2_h_ff;
   end

   // control registers; sweep the gradient stores after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         iss_on_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         iss_on_ff  <= iss_on_in;
         p1_vld_ff  <= iss_act;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      iss_ff <= iss_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      if (take) begin
         kind_ff <= req_kind;
         x_ff    <= req_value;
         g_ff    <= req_grad;
      end
      if (start_run) begin
         base_ff <= req_base;
      end
      // stage 1: table data on its way
      p1_last_ff <= iss_act && (iss_ff == ISS_LAST);
      p1_addr_ff <= pm_rd_addr;
      // stage 2: hinge distance
      p2_last_ff  <= p1_last_ff;
      p2_addr_ff  <= p1_addr_ff;
      p2_h_ff     <= H_W'(pm_offset) - H_W'(x_ff);
      p2_slope_ff <= pm_slope;
      // stage 3: products
      p3_last_ff <= p2_last_ff;
      p3_addr_ff <= p2_addr_ff;
      p3_hpos_ff <= !p2_h_ff[H_W-1] && (p2_h_ff != '0);
      p3_term_ff <= pla_pkg::PROD_W'(p2_slope_ff) * pla_pkg::PROD_W'(mul_op);
      p3_gh_ff   <= pla_pkg::PROD_W'(g_ff) * pla_pkg::PROD_W'(p2_h_ff);
   end

   assign eng_item          = res_ff;
   assign eng_stat.clearing = (state_ff == ST_CLEAR);
   assign eng_stat.busy     = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> dv/tb_piecewise_linear_activation_top.sv
// Self-checking testbench for piecewise_linear_activation_top: hinge table writes, forward
// and backward passes, gradient store reads and clears, checked against an in-bench predictor.
// Depends on pla_pkg and the piecewise_linear_activation_top RTL only.
`timescale 1ns / 1ps

module tb_piecewise_linear_activation_top;

   localparam int NEURONS     = pla_pkg::NEURONS_DEF;
   localparam int SEGMENTS    = pla_pkg::SEGMENTS_DEF;
   localparam int ENTRIES     = NEURONS * SEGMENTS;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int DRAIN_CYCLES = 40;
   localparam longint STORE_MAX = 64'sd140737488355327;
   localparam longint STORE_MIN = -64'sd140737488355328;
   localparam logic [pla_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pla_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [pla_pkg::KIND_W-1:0]     req_tuser = KIND_UNUSED;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pla_pkg::RES_W-1:0]      rsp_tdata;
   logic [0:0]                     rsp_tuser;

   // shadow copy of the block's tables and gradient stores
   logic signed [15:0] slope_mem [ENTRIES];
   logic signed [15:0] offset_mem [ENTRIES];
   bit                 slope_set [ENTRIES];
   bit                 offset_set [ENTRIES];
   longint             slope_grad_acc [ENTRIES];
   longint             offset_grad_acc [ENTRIES];
   bit                 in_pool [NEURONS];
   logic [7:0]         ready_neurons [$];

   pla_pkg::rsp_item_type pending_outputs [$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   bit                    quiet_mode = 1'b0;

   piecewise_linear_activation_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stall the result channel now and then, never during a quiet stretch
   always @(posedge clock) begin
      rsp_tready <= quiet_mode || ($urandom_range(99) >= 16);
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // clip a gradient store entry to 48 bits
   function automatic longint clip48(input longint v);
      if (v > STORE_MAX) return STORE_MAX;
      if (v < STORE_MIN) return STORE_MIN;
      return v;
   endfunction

   // Q16.16 to Q8.8, round half up, clip to 16 bits
   function automatic pla_pkg::rsp_item_type round_q88(input longint acc);
      pla_pkg::rsp_item_type item;
      longint                r;
      r = (acc + 128) >>> 8;
      item.saturated = 1'b0;
      if (r > 32767) begin
         r = 32767;
         item.saturated = 1'b1;
      end
      if (r < -32768) begin
         r = -32768;
         item.saturated = 1'b1;
      end
      item.result = r[pla_pkg::RES_W-1:0];
      return item;
   endfunction

   // apply one accepted request to the shadow state and queue its result, if any
   task automatic predict_activation(input logic [pla_pkg::KIND_W-1:0] kind,
                                     input logic [7:0] n,
                                     input logic [2:0] s, input logic signed [15:0] v,
                                     input logic signed [15:0] g);
      int unsigned           base;
      int unsigned           idx;
      longint                acc;
      longint                hinge;
      longint                od;
      bit                    full;
      pla_pkg::rsp_item_type item;
      base = n * SEGMENTS;
      idx  = base + s;
      item = '0;
      case (kind)
         pla_pkg::KIND_WR_SLOPE: begin
            slope_mem[idx] = v;
            slope_set[idx] = 1'b1;
         end
         pla_pkg::KIND_WR_OFFSET: begin
            offset_mem[idx] = v;
            offset_set[idx] = 1'b1;
         end
         pla_pkg::KIND_FORWARD: begin
            acc = (v > 0) ? longint'(v) * 256 : 0;
            for (int k = 0; k < SEGMENTS; k++) begin
               hinge = longint'(offset_mem[base+k]) - longint'(v);
               if (hinge > 0) acc += longint'(slope_mem[base+k]) * hinge;
            end
            pending_outputs.push_back(round_q88(acc));
         end
         pla_pkg::KIND_BACKWARD: begin
            acc = (v > 0) ? longint'(g) * 256 : 0;
            for (int k = 0; k < SEGMENTS; k++) begin
               hinge = longint'(offset_mem[base+k]) - longint'(v);
               if (hinge > 0) begin
                  od = longint'(g) * longint'(slope_mem[base+k]);
                  slope_grad_acc[base+k]  = clip48(slope_grad_acc[base+k] + longint'(g) * hinge);
                  offset_grad_acc[base+k] = clip48(offset_grad_acc[base+k] + od);
                  acc -= od;
               end
            end
            pending_outputs.push_back(round_q88(acc));
         end
         pla_pkg::KIND_RD_SGRAD: begin
            item.result = slope_grad_acc[idx][pla_pkg::RES_W-1:0];
            pending_outputs.push_back(item);
         end
         pla_pkg::KIND_RD_OGRAD: begin
            item.result = offset_grad_acc[idx][pla_pkg::RES_W-1:0];
            pending_outputs.push_back(item);
         end
         pla_pkg::KIND_CLEAR: begin
            for (int k = 0; k < ENTRIES; k++) begin
               slope_grad_acc[k]  = 0;
               offset_grad_acc[k] = 0;
            end
         end
         default: begin
         end
      endcase
      // a neuron becomes usable for passes once every hinge of it was written
      if ((kind == pla_pkg::KIND_WR_SLOPE || kind == pla_pkg::KIND_WR_OFFSET)
          && !in_pool[n]) begin
         full = 1'b1;
         for (int k = 0; k < SEGMENTS; k++)
            if (!slope_set[base+k] || !offset_set[base+k]) full = 1'b0;
         if (full) begin
            in_pool[n] = 1'b1;
            ready_neurons.push_back(n);
         end
      end
   endtask

   // present one request, hold it until accepted, then predict its effect
   task automatic send_request(input logic [pla_pkg::KIND_W-1:0] kind, input logic [7:0] n,
                               input logic [2:0] s, input logic signed [15:0] v,
                               input logic signed [15:0] g);
      if (!quiet_mode && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pla_pkg::REQ_DATA_W'({g, v, s, n});
      do @(posedge clock); while (!req_tready);
      predict_activation(kind, n, s, v, g);
   endtask

   // mix of full-range, small and corner values
   function automatic logic signed [15:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 25) return 16'($urandom);
      if (sel < 75) return 16'($urandom_range(1023) - 512);
      case ($urandom_range(4))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   // check each delivered result against the oldest prediction
   always @(posedge clock) begin
      pla_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h sat %b", rsp_tdata, rsp_tuser));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata !== want.result)
               report_mismatch($sformatf("result %h, want %h", rsp_tdata, want.result));
            if (rsp_tuser[0] !== want.saturated)
               report_mismatch($sformatf("saturated %b, want %b (result %h)",
                                         rsp_tuser[0], want.saturated, want.result));
         end
      end
   end

   // hinges with extreme slopes and offsets, passes at the ends of the input range
   task automatic test_hinge_extremes();
      logic signed [15:0] slopes [SEGMENTS] =
         '{16'sh7FFF, 16'sh8000, 16'sd256, -16'sd128, 16'sd1, 16'sd0, -16'sd1, 16'sd64};
      logic signed [15:0] offsets [SEGMENTS] =
         '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd512, -16'sd1, 16'sh7FFF, 16'sd100, -16'sd512};
      for (int k = 0; k < SEGMENTS; k++) begin
         send_request(pla_pkg::KIND_WR_SLOPE, 8'd0, 3'(k), slopes[k], 16'sd0);
         send_request(pla_pkg::KIND_WR_OFFSET, 8'd0, 3'(k), offsets[k], 16'sd0);
      end
      send_request(pla_pkg::KIND_FORWARD, 8'd0, 3'd0, 16'sh8000, 16'sd0);
      send_request(pla_pkg::KIND_FORWARD, 8'd0, 3'd0, 16'sh7FFF, 16'sd0);
      send_request(pla_pkg::KIND_FORWARD, 8'd0, 3'd0, 16'sd0, 16'sd0);
      send_request(pla_pkg::KIND_BACKWARD, 8'd0, 3'd0, 16'sh8000, 16'sh7FFF);
      send_request(pla_pkg::KIND_BACKWARD, 8'd0, 3'd7, 16'sd100, 16'sh8000);
   endtask

   // gradient store readback, clear and the unused kind
   task automatic test_gradient_store();
      send_request(pla_pkg::KIND_RD_SGRAD, 8'd0, 3'd0, 16'sd0, 16'sd0);
      send_request(pla_pkg::KIND_RD_OGRAD, 8'd0, 3'd3, 16'sd0, 16'sd0);
      send_request(KIND_UNUSED, 8'hFF, 3'd7, 16'sh7FFF, 16'sh8000);
      send_request(pla_pkg::KIND_WR_SLOPE, 8'hFF, 3'd7, 16'sh8000, 16'sd0);
      send_request(pla_pkg::KIND_RD_SGRAD, 8'hFF, 3'd7, 16'sd0, 16'sd0);
      send_request(pla_pkg::KIND_CLEAR, 8'd0, 3'd0, 16'sd0, 16'sd0);
      send_request(pla_pkg::KIND_RD_OGRAD, 8'd0, 3'd3, 16'sd0, 16'sd0);
   endtask

   // fill tables for random neurons, then a random mix weighted toward passes
   task automatic test_random_traffic();
      logic [7:0]         n;
      logic [2:0]         s;
      logic signed [15:0] x;
      int unsigned        sel;
      for (int i = 0; i < 12; i++) begin
         n = 8'($urandom);
         for (int k = 0; k < SEGMENTS; k++) begin
            send_request(pla_pkg::KIND_WR_SLOPE, n, 3'(k), pick_value(), 16'($urandom));
            send_request(pla_pkg::KIND_WR_OFFSET, n, 3'(k), pick_value(), 16'($urandom));
         end
      end
      for (int i = 0; i < 500; i++) begin
         quiet_mode = (i >= 200 && i < 320);
         sel = $urandom_range(99);
         n = ready_neurons[$urandom_range(ready_neurons.size() - 1)];
         s = 3'($urandom);
         if (sel < 20) begin
            if ($urandom_range(1)) n = 8'($urandom);
            send_request((sel < 10) ? pla_pkg::KIND_WR_SLOPE : pla_pkg::KIND_WR_OFFSET,
                         n, s, pick_value(), 16'($urandom));
         end else if (sel < 75) begin
            // aim half the inputs near a hinge
            if ($urandom_range(1))
               x = offset_mem[n*SEGMENTS + s] + 16'($urandom_range(64) - 32);
            else
               x = pick_value();
            send_request((sel < 50) ? pla_pkg::KIND_FORWARD : pla_pkg::KIND_BACKWARD,
                         n, s, x, pick_value());
         end else if (sel < 97) begin
            if ($urandom_range(9) < 3) n = 8'($urandom);
            send_request((sel < 86) ? pla_pkg::KIND_RD_SGRAD : pla_pkg::KIND_RD_OGRAD,
                         n, s, 16'($urandom), 16'($urandom));
         end else if (sel < 98) begin
            send_request(pla_pkg::KIND_CLEAR, 8'($urandom), s, 16'($urandom),
                         16'($urandom));
         end else begin
            send_request(KIND_UNUSED, 8'($urandom), s, 16'($urandom), 16'($urandom));
         end
      end
      quiet_mode = 1'b0;
   endtask

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_hinge_extremes();
      test_gradient_store();
      test_random_traffic();
      req_tvalid <= 1'b0;
      // drain outstanding results, then watch for strays
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
